@@ design/tgcs_pkg.sv @@
package tgcs_pkg;

    // Caret and grid geometry fixed by the console format
    localparam int CARET_W = 10;
    localparam int COL_W   = 5;
    localparam int ROW_W   = 3;
    localparam int CODE_W  = 6;
    localparam int CHAR_W  = 8;

    localparam logic [CARET_W-1:0] CARET_MAX = 10'd1023;
    localparam logic [CARET_W-1:0] LINE_LEN  = 10'd32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BS_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RET_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PMAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_LO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_HI    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE  = 3'd7;

    typedef struct packed {
        logic [3:0]        lines;
        logic              scroll_en;
        logic [CHAR_W-1:0] bs_code;
        logic [CHAR_W-1:0] ret_code;
        logic [CODE_W-1:0] pmax;
        logic [CODE_W-1:0] sp_lo;
        logic [CODE_W-1:0] sp_hi;
        logic              inverse;
    } t_cfg;

    typedef struct packed {
        logic               wr;
        logic               scroll;
        logic [CARET_W-1:0] caret;
        logic [CARET_W-1:0] len;
    } t_step;

endpackage

@@ design/tgcs_grid_ram.sv @@
module tgcs_grid_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tgcs_pkg::CODE_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [tgcs_pkg::CODE_W-1:0] o_rdata
);

    logic [tgcs_pkg::CODE_W-1:0] r_mem [DEPTH];
    logic [tgcs_pkg::CODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tgcs_caret_alu.sv @@
module tgcs_caret_alu #(
    parameter int MAX_LINES = 8
) (
    input  tgcs_pkg::t_cfg                  i_cfg,
    input  logic [tgcs_pkg::CHAR_W-1:0]     i_code,
    input  logic [tgcs_pkg::CARET_W-1:0]    i_caret,
    output tgcs_pkg::t_step                 o_step
);

    localparam logic [3:0] LINES_CAP = (MAX_LINES > 15) ? 4'd15 : 4'(MAX_LINES);

    logic [3:0]                   lines_eff;
    logic [tgcs_pkg::CARET_W-1:0] len;
    logic [tgcs_pkg::CARET_W-1:0] last;
    logic [tgcs_pkg::COL_W:0]     line_next;
    logic [tgcs_pkg::CARET_W-1:0] c_dec, c_ret, c_inc, c_new;
    logic                         is_bs, is_ret, printable;

    always_comb begin
        // Clamp the line count into one .. MAX_LINES, capped at 15
        if (i_cfg.lines == 4'd0) begin
            lines_eff = 4'd1;
        end else if (i_cfg.lines > LINES_CAP) begin
            lines_eff = LINES_CAP;
        end else begin
            lines_eff = i_cfg.lines;
        end
        len  = {1'b0, lines_eff, 5'b0};
        last = len - tgcs_pkg::LINE_LEN;

        is_bs     = (i_code == i_cfg.bs_code);
        is_ret    = (i_code == i_cfg.ret_code);
        printable = (i_code <= {2'b00, i_cfg.pmax}) ||
                    ((i_code >= {2'b00, i_cfg.sp_lo}) && (i_code <= {2'b00, i_cfg.sp_hi}));

        c_dec     = (i_caret == '0) ? '0 : i_caret - 10'd1;
        line_next = {1'b0, i_caret[tgcs_pkg::CARET_W-1:tgcs_pkg::COL_W]} + 6'd1;
        c_ret     = line_next[tgcs_pkg::COL_W] ? tgcs_pkg::CARET_MAX
                                               : {line_next[tgcs_pkg::COL_W-1:0], 5'b0};
        c_inc     = (i_caret == tgcs_pkg::CARET_MAX) ? tgcs_pkg::CARET_MAX : i_caret + 10'd1;

        priority if (is_bs) begin
            c_new = c_dec;
        end else if (is_ret) begin
            c_new = c_ret;
        end else begin
            c_new = c_inc;
        end

        o_step.wr     = !is_bs && !is_ret && printable && (i_caret < len);
        o_step.scroll = (c_new == len) && i_cfg.scroll_en;
        o_step.caret  = o_step.scroll ? last : c_new;
        o_step.len    = len;
    end

endmodule

@@ design/text_grid_cursor_scroll.sv @@
// Channel   Direction  Handshake                  Word
// in        sink       i_in_valid / o_in_stall     i_char_code
// out       source     o_out_valid / i_out_stall   o_cell_*, o_scrolled, o_caret_now
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item passes the accept, caret step and result word states when the grid
// does not scroll; a scroll adds the copy loop, which walks all lines*32 cells
// of the grid RAM one cell a cycle through its single write port.
// After reset a clearing pass writes zero to all MAX_LINES*32 cells, one a
// cycle, while o_in_stall is held high; configuration writes are taken always.
// A stalled result word holds in the output register and the block stays busy.
module text_grid_cursor_scroll #(
    parameter int MAX_LINES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [tgcs_pkg::CHAR_W-1:0]        i_char_code,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_cell_written,
    output logic [tgcs_pkg::COL_W-1:0]         o_cell_column,
    output logic [tgcs_pkg::ROW_W-1:0]         o_cell_row,
    output logic [tgcs_pkg::CODE_W-1:0]        o_cell_code,
    output logic                               o_cell_inverted,
    output logic                               o_scrolled,
    output logic [tgcs_pkg::CARET_W-1:0]       o_caret_now,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tgcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);

    localparam int DEPTH = MAX_LINES * 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = tgcs_pkg::CARET_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_pend, n_pend;
    logic [AW-1:0]                 r_pend_addr;
    logic                          r_pend_zero;
    logic [tgcs_pkg::CARET_W-1:0]  r_caret;
    logic [tgcs_pkg::CARET_W-1:0]  r_len;
    logic [tgcs_pkg::CHAR_W-1:0]   r_code;
    tgcs_pkg::t_cfg                r_cfg;
    tgcs_pkg::t_step               step;

    logic [IW-1:0]                 len_ext, last_ext, src_idx;
    logic                          scan_live;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [tgcs_pkg::CODE_W-1:0]   ram_wdata, ram_rdata;

    logic                          r_wr, r_inv, r_scr;
    logic [tgcs_pkg::COL_W-1:0]    r_col;
    logic [tgcs_pkg::ROW_W-1:0]    r_row;
    logic [tgcs_pkg::CODE_W-1:0]   r_cell_code;
    logic [tgcs_pkg::CARET_W-1:0]  r_caret_now;

    // Caret step and printable decision for the held code
    tgcs_caret_alu #(.MAX_LINES(MAX_LINES)) u_alu (
        .i_cfg   (r_cfg),
        .i_code  (r_code),
        .i_caret (r_caret),
        .o_step  (step)
    );

    tgcs_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == ST_OUT);

    // Scroll walk: read cell idx+32, write it to idx in the following cycle; the
    // last line is blanked instead of copied.
    assign len_ext   = {1'b0, r_len};
    assign last_ext  = len_ext - IW'(32);
    assign src_idx   = r_idx + IW'(32);
    assign scan_live = (r_idx < len_ext);
    assign ram_raddr = src_idx[AW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_STEP: begin
                ram_we    = step.wr;
                ram_waddr = r_caret[AW-1:0];
                ram_wdata = r_code[tgcs_pkg::CODE_W-1:0];
            end
            ST_SCROLL: begin
                ram_we    = r_pend;
                ram_waddr = r_pend_addr;
                ram_wdata = r_pend_zero ? '0 : ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_idx   = '0;
                n_state = step.scroll ? ST_SCROLL : ST_OUT;
            end
            ST_SCROLL: begin
                if (scan_live) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + IW'(1);
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_caret <= '0;
            r_cfg.lines     <= 4'd8;
            r_cfg.scroll_en <= 1'b1;
            r_cfg.bs_code   <= 8'd0;
            r_cfg.ret_code  <= 8'd0;
            r_cfg.pmax      <= 6'd30;
            r_cfg.sp_lo     <= 6'd32;
            r_cfg.sp_hi     <= 6'd35;
            r_cfg.inverse   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (r_state == ST_STEP) begin
                r_caret <= step.caret;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tgcs_pkg::CFG_LINES:    r_cfg.lines     <= i_cfg_data[3:0];
                    tgcs_pkg::CFG_SCROLL:   r_cfg.scroll_en <= i_cfg_data[0];
                    tgcs_pkg::CFG_BS_CODE:  r_cfg.bs_code   <= i_cfg_data;
                    tgcs_pkg::CFG_RET_CODE: r_cfg.ret_code  <= i_cfg_data;
                    tgcs_pkg::CFG_PMAX:     r_cfg.pmax      <= i_cfg_data[5:0];
                    tgcs_pkg::CFG_SP_LO:    r_cfg.sp_lo     <= i_cfg_data[5:0];
                    tgcs_pkg::CFG_SP_HI:    r_cfg.sp_hi     <= i_cfg_data[5:0];
                    tgcs_pkg::CFG_INVERSE:  r_cfg.inverse   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: code, scroll bookkeeping and the result word
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_code <= i_char_code;
        end
        if (r_state == ST_STEP) begin
            r_len       <= step.len;
            r_wr        <= step.wr;
            r_col       <= step.wr ? r_caret[tgcs_pkg::COL_W-1:0] : '0;
            r_row       <= step.wr ? r_caret[tgcs_pkg::COL_W +: tgcs_pkg::ROW_W] : '0;
            r_cell_code <= step.wr ? r_code[tgcs_pkg::CODE_W-1:0] : '0;
            r_inv       <= step.wr ? r_cfg.inverse : 1'b0;
            r_scr       <= step.scroll;
            r_caret_now <= step.caret;
        end
        if (r_state == ST_SCROLL) begin
            r_pend_addr <= r_idx[AW-1:0];
            r_pend_zero <= (r_idx >= last_ext);
        end
    end

    assign o_cell_written  = r_wr;
    assign o_cell_column   = r_col;
    assign o_cell_row      = r_row;
    assign o_cell_code     = r_cell_code;
    assign o_cell_inverted = r_inv;
    assign o_scrolled      = r_scr;
    assign o_caret_now     = r_caret_now;

    // Hold off new words while a result waits
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result word waits");

    // No store means a zero cell description
    a_empty_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_cell_written) |->
            (o_cell_column == '0 && o_cell_row == '0 &&
             o_cell_code == '0 && !o_cell_inverted))
        else $error("cell fields set without a store");

    // A scroll leaves the caret at the start of a line
    a_scroll_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_caret_now[tgcs_pkg::COL_W-1:0] == '0))
        else $error("scroll left caret mid-line");

    // Result word follows either the step or the end of the scroll walk
    a_out_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_STEP || $past(r_state) == ST_SCROLL))
        else $error("result word raised from an unexpected state");

endmodule
